### hdl/l10ti_pkg.sv
// Shared types, constants and elaboration-time table builders for the
// table-based log10 block. Depends on nothing; every other file imports it.

package l10ti_pkg;

  // Input format: IEEE 754 double.
  localparam int IN_W      = 64;
  localparam int EXP_BITS  = 11;
  localparam int MANT_BITS = 52;
  localparam logic [EXP_BITS-1:0] EXP_BIAS = 11'd1023;

  // Table and fixed-point shape.
  localparam int INDEX_BITS = 10;
  localparam int FRAC_BITS  = 40;
  localparam int REM_BITS   = MANT_BITS - INDEX_BITS;
  localparam int ROM_DEPTH  = (1 << INDEX_BITS) + 1;
  localparam int OUT_W      = 51;

  // The table is split into even and odd banks so that entries i and i+1
  // always sit in different banks.
  localparam int EVEN_DEPTH = (1 << (INDEX_BITS - 1)) + 1;
  localparam int ODD_DEPTH  = 1 << (INDEX_BITS - 1);
  localparam int EVEN_AW    = INDEX_BITS;
  localparam int ODD_AW     = INDEX_BITS - 1;

  // log10(2) is held with 63 fraction bits; table entries are formed from
  // a Q60 log2 times that constant, so they are shifted down by 123 - FRAC.
  localparam int Q_BITS    = 63;
  localparam int ROM_SHIFT = 123 - FRAC_BITS;
  localparam int E_SHIFT   = Q_BITS - FRAC_BITS;
  localparam int EPROD_W   = EXP_BITS + Q_BITS;
  localparam int Q_LO_W    = 32;
  localparam int Q_HI_W    = Q_BITS - Q_LO_W;

  // Interpolation multiplier split over the remainder bits.
  localparam int REM_LO_W = REM_BITS / 2;
  localparam int REM_HI_W = REM_BITS - REM_LO_W;

  // Answer for zero and negative arguments: -1000 in the output format.
  localparam logic signed [OUT_W-1:0] NONPOS_LOG =
    OUT_W'(-(longint'(1000) <<< FRAC_BITS));

  typedef logic [FRAC_BITS-1:0] rom_table_t [ROM_DEPTH];
  typedef logic [FRAC_BITS-1:0] even_bank_t [EVEN_DEPTH];
  typedef logic [FRAC_BITS-1:0] odd_bank_t  [ODD_DEPTH];

  // log2 of a Q62 value in [1,2], returned as Q60, by repeated squaring.
  function automatic logic [63:0] log2_q60(input logic [63:0] m);
    logic [63:0]  y;
    logic [63:0]  r;
    logic [127:0] p;
    y = m;
    r = '0;
    if (y[63]) begin
      y    = y >> 1;
      r[60] = 1'b1;
    end
    for (int k = 1; k <= 60; k++) begin
      p = {64'd0, y} * {64'd0, y};
      y = p[125:62];
      if (y[63]) begin
        y        = y >> 1;
        r[60-k]  = 1'b1;
      end
    end
    return r;
  endfunction

  // log10(2) = 1 / log2(10) as Q63, by restoring long division.
  function automatic logic [63:0] log10_2_q63();
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] q;
    d   = (64'd3 << 60) + log2_q60(64'd5 << 60);
    rem = 64'd1 << 60;
    q   = '0;
    for (int k = 0; k < Q_BITS; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= d) begin
        rem  = rem - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [63:0] LOG10_2_Q63 = log10_2_q63();
  localparam logic [Q_LO_W-1:0] LOG10_2_LO = LOG10_2_Q63[Q_LO_W-1:0];
  localparam logic [Q_HI_W-1:0] LOG10_2_HI = LOG10_2_Q63[Q_BITS-1:Q_LO_W];

  // Entry i holds round(log10(1 + i/2^INDEX_BITS) * 2^FRAC_BITS).
  function automatic rom_table_t build_rom();
    rom_table_t   t;
    logic [63:0]  m;
    logic [127:0] p;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      m    = (64'd1 << 62) + (64'(i) << (62 - INDEX_BITS));
      p    = {64'd0, log2_q60(m)} * {64'd0, LOG10_2_Q63};
      p    = p + (128'd1 << (ROM_SHIFT - 1));
      t[i] = FRAC_BITS'(p >> ROM_SHIFT);
    end
    return t;
  endfunction

  function automatic even_bank_t even_bank(input rom_table_t t);
    even_bank_t b;
    for (int j = 0; j < EVEN_DEPTH; j++) begin
      b[j] = t[2*j];
    end
    return b;
  endfunction

  function automatic odd_bank_t odd_bank(input rom_table_t t);
    odd_bank_t b;
    for (int j = 0; j < ODD_DEPTH; j++) begin
      b[j] = t[2*j+1];
    end
    return b;
  endfunction

  // Number of bits needed to hold v.
  function automatic int bits_for(input logic [63:0] v);
    int n;
    n = 1;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

  localparam rom_table_t LOG_ROM = build_rom();

  // The log curve is concave, so the first step of the table is the largest
  // difference between neighbouring entries.
  localparam int DIFF_BITS = bits_for(64'(LOG_ROM[1]));

endpackage

### hdl/l10ti_if.sv
// Handshake channels for the table-based log10 block: the argument channel
// and the result channel. Depends on l10ti_pkg for the field widths.

interface l10ti_in_if import l10ti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink   (input valid, input x_bits, output ready);
endinterface

interface l10ti_out_if import l10ti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] log_value;
  logic                    nonpositive;

  modport source (output valid, output log_value, output nonpositive, input ready);
  modport sink   (input valid, input log_value, input nonpositive, output ready);
endinterface

### hdl/log10_table_interpolation.sv
// Top level of the table-based log10 block: a five-stage pipeline with the
// mantissa table held in two registered-read ROM banks.
// Depends on l10ti_pkg and the channel interfaces in l10ti_if.sv.
//
// Usage: in_chan carries the bit pattern of an IEEE double per item;
// out_chan returns log10 of it with 40 fraction bits, plus a flag that is
// set when the argument was zero or had its sign bit set (result -1000).
// The result passes through the stage 1 to 4 registers into the output
// register, where it waits until it is taken.
// One item is accepted every cycle while the receiver takes
// results; the ROM banks each have one read port, and entries i and i+1
// come from different banks so both reads happen in the same cycle.
// All stages advance together: when a result waits untaken in the output
// register, the whole pipeline holds and in_chan.ready is low, so nothing
// is lost or repeated. Empty stages ahead of the output still advance only
// with the rest. Synchronous active-low reset clears every valid bit; the
// tables are constants built at elaboration, so no clearing pass follows
// reset and items are accepted from the first cycle after it.

module log10_table_interpolation import l10ti_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  l10ti_in_if.sink           in_chan,
  l10ti_out_if.source        out_chan
);

  localparam even_bank_t ROM_EVEN = even_bank(LOG_ROM);
  localparam odd_bank_t  ROM_ODD  = odd_bank(LOG_ROM);

  // Pipeline advance: everything moves when the output register is empty or its result is being taken.
  logic adv;
  logic out_valid_r;
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Field decode of the incoming item.
  logic [EXP_BITS-1:0]   in_ex;
  logic [INDEX_BITS-1:0] in_idx;
  logic [REM_BITS-1:0]   in_frac;
  logic                  in_nonpos;
  logic                  in_pos_exp;
  logic [EXP_BITS-1:0]   in_mag;
  logic [INDEX_BITS:0]   in_idx_inc;
  logic [EVEN_AW-1:0]    even_addr;
  logic [ODD_AW-1:0]     odd_addr;

  always_comb begin
    in_ex      = in_chan.x_bits[MANT_BITS +: EXP_BITS];
    in_idx     = in_chan.x_bits[REM_BITS +: INDEX_BITS];
    in_frac    = in_chan.x_bits[REM_BITS-1:0];
    in_nonpos  = in_chan.x_bits[IN_W-1] || (in_chan.x_bits == '0);
    in_pos_exp = (in_ex >= EXP_BIAS);
    in_mag     = in_pos_exp ? (in_ex - EXP_BIAS) : (EXP_BIAS - in_ex);
    in_idx_inc = {1'b0, in_idx} + 1'b1;
    even_addr  = in_idx_inc[INDEX_BITS:1];
    odd_addr   = in_idx[INDEX_BITS-1:1];
  end

  // Stage 1: decoded fields and both ROM bank reads.
  logic                  s1_valid_r;
  logic                  s1_nonpos_r;
  logic                  s1_pos_exp_r;
  logic                  s1_odd_r;
  logic [EXP_BITS-1:0]   s1_mag_r;
  logic [REM_BITS-1:0]   s1_frac_r;
  logic [FRAC_BITS-1:0]  rom_even_r;
  logic [FRAC_BITS-1:0]  rom_odd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_nonpos_r  <= in_nonpos;
      s1_pos_exp_r <= in_pos_exp;
      s1_odd_r     <= in_idx[0];
      s1_mag_r     <= in_mag;
      s1_frac_r    <= in_frac;
      rom_even_r   <= ROM_EVEN[even_addr];
      rom_odd_r    <= ROM_ODD[odd_addr];
    end
  end

  // Stage 2: order the two entries, take their difference, and form the
  // partial products of the exponent term.
  logic [FRAC_BITS-1:0]         s2_lo_nxt;
  logic [FRAC_BITS-1:0]         s2_hi_nxt;
  logic [FRAC_BITS-1:0]         s2_diff_full;
  logic                         s2_valid_r;
  logic                         s2_nonpos_r;
  logic                         s2_pos_exp_r;
  logic [REM_BITS-1:0]          s2_frac_r;
  logic [FRAC_BITS-1:0]         s2_lo_r;
  logic [DIFF_BITS-1:0]         s2_diff_r;
  logic [EXP_BITS+Q_LO_W-1:0]   s2_pe_lo_r;
  logic [EXP_BITS+Q_HI_W-1:0]   s2_pe_hi_r;

  always_comb begin
    s2_lo_nxt    = s1_odd_r ? rom_odd_r : rom_even_r;
    s2_hi_nxt    = s1_odd_r ? rom_even_r : rom_odd_r;
    s2_diff_full = s2_hi_nxt - s2_lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nonpos_r  <= s1_nonpos_r;
      s2_pos_exp_r <= s1_pos_exp_r;
      s2_frac_r    <= s1_frac_r;
      s2_lo_r      <= s2_lo_nxt;
      s2_diff_r    <= DIFF_BITS'(s2_diff_full);
      s2_pe_lo_r   <= (EXP_BITS+Q_LO_W)'(s1_mag_r) * (EXP_BITS+Q_LO_W)'(LOG10_2_LO);
      s2_pe_hi_r   <= (EXP_BITS+Q_HI_W)'(s1_mag_r) * (EXP_BITS+Q_HI_W)'(LOG10_2_HI);
    end
  end

  // Stage 3: interpolation partial products; the exponent term is
  // assembled and rounded half up.
  logic [EPROD_W-1:0]             s3_eprod;
  logic [EPROD_W-1:0]             s3_eround;
  logic                           s3_valid_r;
  logic                           s3_nonpos_r;
  logic                           s3_pos_exp_r;
  logic [FRAC_BITS-1:0]           s3_lo_r;
  logic [OUT_W-1:0]               s3_eterm_r;
  logic [DIFF_BITS+REM_LO_W-1:0]  s3_pi_lo_r;
  logic [DIFF_BITS+REM_HI_W-1:0]  s3_pi_hi_r;

  always_comb begin
    s3_eprod  = (EPROD_W'(s2_pe_hi_r) << Q_LO_W) + EPROD_W'(s2_pe_lo_r)
                + (EPROD_W'(1) << (E_SHIFT - 1));
    s3_eround = s3_eprod >> E_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nonpos_r  <= s2_nonpos_r;
      s3_pos_exp_r <= s2_pos_exp_r;
      s3_lo_r      <= s2_lo_r;
      s3_eterm_r   <= OUT_W'(s3_eround);
      s3_pi_lo_r   <= (DIFF_BITS+REM_LO_W)'(s2_diff_r)
                      * (DIFF_BITS+REM_LO_W)'(s2_frac_r[REM_LO_W-1:0]);
      s3_pi_hi_r   <= (DIFF_BITS+REM_HI_W)'(s2_diff_r)
                      * (DIFF_BITS+REM_HI_W)'(s2_frac_r[REM_BITS-1:REM_LO_W]);
    end
  end

  // Stage 4: interpolation term assembled and rounded half up.
  localparam int IPROD_W = DIFF_BITS + REM_BITS + 1;
  logic [IPROD_W-1:0]   s4_iprod;
  logic [IPROD_W-1:0]   s4_iround;
  logic                 s4_valid_r;
  logic                 s4_nonpos_r;
  logic                 s4_pos_exp_r;
  logic [FRAC_BITS-1:0] s4_lo_r;
  logic [OUT_W-1:0]     s4_eterm_r;
  logic [DIFF_BITS-1:0] s4_iterm_r;

  always_comb begin
    s4_iprod  = (IPROD_W'(s3_pi_hi_r) << REM_LO_W) + IPROD_W'(s3_pi_lo_r)
                + (IPROD_W'(1) << (REM_BITS - 1));
    s4_iround = s4_iprod >> REM_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nonpos_r  <= s3_nonpos_r;
      s4_pos_exp_r <= s3_pos_exp_r;
      s4_lo_r      <= s3_lo_r;
      s4_eterm_r   <= s3_eterm_r;
      s4_iterm_r   <= DIFF_BITS'(s4_iround);
    end
  end

  // Stage 5: final sum into the output register, wrapping at the
  // output width; zero and negative arguments take the fixed answer.
  logic [OUT_W-1:0]        mant_sum;
  logic [OUT_W-1:0]        log_nxt;
  logic signed [OUT_W-1:0] log_value_r;
  logic                    nonpos_r;

  always_comb begin
    mant_sum = OUT_W'(s4_lo_r) + OUT_W'(s4_iterm_r);
    if (s4_nonpos_r) begin
      log_nxt = NONPOS_LOG;
    end else if (s4_pos_exp_r) begin
      log_nxt = mant_sum + s4_eterm_r;
    end else begin
      log_nxt = mant_sum - s4_eterm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      log_value_r <= log_nxt;
      nonpos_r    <= s4_nonpos_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.log_value   = log_value_r;
  assign out_chan.nonpositive = nonpos_r;

endmodule

### verif/log10_table_interpolation_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for log10_table_interpolation: drives IEEE double
// patterns, predicts each table-interpolated log10 result and checks it.
// Depends on l10ti_pkg, the channel interfaces and the block's top level.

module log10_table_interpolation_test;
  import l10ti_pkg::*;

  // Fixed-point shape of the predictor, kept apart from the design's own.
  localparam int TABLE_IDX_W = 10;
  localparam int FRAC_W      = 40;
  localparam int REM_W       = 52 - TABLE_IDX_W;
  localparam int TABLE_DEPTH = (1 << TABLE_IDX_W) + 1;
  localparam logic [10:0] ONE_EXP = 11'd1023;

  localparam int ITEMS_PER_PHASE  = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 10;
  localparam int MAX_REPORT_LINES = 100;

  typedef struct packed {
    logic signed [OUT_W-1:0] log_value;
    logic                    nonpositive;
  } log_result_t;

  // Shapes of random argument.
  typedef enum int {
    ARG_RAW,
    ARG_POSITIVE,
    ARG_NEAR_ONE,
    ARG_EDGE_EXP,
    ARG_EDGE_INDEX,
    ARG_EDGE_REM
  } arg_kind_e;

  logic clk;
  logic rst_n;

  l10ti_in_if  in_chan ();
  l10ti_out_if out_chan ();

  log10_table_interpolation DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [63:0]     mant_log_table [TABLE_DEPTH];
  logic [63:0]     log10_two_q63;
  logic [IN_W-1:0] pending_args [$];
  log_result_t     expected_logs [$];
  int              mismatch_count = 0;
  int              send_idle_pct  = 19;
  int              recv_idle_pct  = 61;

  // log2 of a Q62 value in [1,2] as Q60, one result bit per squaring.
  function automatic logic [63:0] log2_q60_of(input logic [63:0] m);
    logic [63:0]  y;
    logic [63:0]  bits;
    logic [127:0] sq;
    y    = m;
    bits = '0;
    if (y[63]) begin
      y        = y >> 1;
      bits[60] = 1'b1;
    end
    for (int k = 1; k <= 60; k++) begin
      sq = 128'(y) * 128'(y);
      y  = sq[125:62];
      if (y[63]) begin
        y            = y >> 1;
        bits[60 - k] = 1'b1;
      end
    end
    return bits;
  endfunction

  // Expected log10 of one double pattern.
  function automatic log_result_t predict_log10(input logic [IN_W-1:0] x);
    log_result_t  res;
    logic [10:0]  ex;
    logic [10:0]  mag;
    int           idx;
    logic [63:0]  rem;
    logic [63:0]  step;
    logic [127:0] eprod;
    logic [127:0] iprod;
    logic [63:0]  sum;
    if (x[63] || x == '0) begin
      sum = 64'd0 - (64'd1000 << FRAC_W);
      res.log_value   = sum[OUT_W-1:0];
      res.nonpositive = 1'b1;
      return res;
    end
    ex  = x[62:52];
    idx = int'(x[51:REM_W]);
    rem = 64'(x[REM_W-1:0]);
    mag = (ex >= ONE_EXP) ? ex - ONE_EXP : ONE_EXP - ex;

    // Exponent term and interpolation term, both rounded half up.
    eprod = 128'(mag) * 128'(log10_two_q63) + (128'd1 << (62 - FRAC_W));
    step  = mant_log_table[idx + 1] - mant_log_table[idx];
    iprod = 128'(step) * 128'(rem) + (128'd1 << (REM_W - 1));

    sum = mant_log_table[idx] + 64'(iprod >> REM_W);
    if (ex >= ONE_EXP) begin
      sum = sum + 64'(eprod >> (63 - FRAC_W));
    end else begin
      sum = sum - 64'(eprod >> (63 - FRAC_W));
    end
    res.log_value   = sum[OUT_W-1:0];
    res.nonpositive = 1'b0;
    return res;
  endfunction

  // Random argument, mostly positive, biased towards field extremes.
  function automatic logic [IN_W-1:0] random_arg();
    logic [IN_W-1:0] x;
    arg_kind_e       kind;
    x    = {$urandom, $urandom};
    kind = arg_kind_e'($urandom_range(int'(ARG_EDGE_REM)));
    if (kind != ARG_RAW) begin
      x[63] = 1'b0;
    end
    case (kind)
      ARG_NEAR_ONE: begin
        x[62:52] = 11'(1011 + $urandom_range(24));
      end
      ARG_EDGE_EXP: begin
        x[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
      end
      ARG_EDGE_INDEX: begin
        x[51:REM_W] = $urandom_range(1) ? '1 : '0;
      end
      ARG_EDGE_REM: begin
        case ($urandom_range(3))
          0: x[REM_W-1:0] = '0;
          1: x[REM_W-1:0] = '1;
          2: x[REM_W-1:0] = 42'h200_0000_0000;
          default: x[REM_W-1:0] = 42'h1FF_FFFF_FFFF;
        endcase
      end
      default: begin
      end
    endcase
    return x;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORT_LINES) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Argument driver: holds each item until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      in_chan.x_bits <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_logs.push_back(predict_log10(in_chan.x_bits));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_args.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_chan.valid  <= 1'b1;
          in_chan.x_bits <= pending_args.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares every taken item with the oldest expectation.
  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_logs.size() == 0) begin
          report_mismatch($sformatf("unexpected result log_value=%h nonpositive=%b",
                                    out_chan.log_value, out_chan.nonpositive));
        end else begin
          want = expected_logs.pop_front();
          if (out_chan.log_value !== want.log_value) begin
            report_mismatch($sformatf("log_value got %h want %h",
                                      out_chan.log_value, want.log_value));
          end
          if (out_chan.nonpositive !== want.nonpositive) begin
            report_mismatch($sformatf("nonpositive got %b want %b",
                                      out_chan.nonpositive, want.nonpositive));
          end
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no item moves for too long.
  initial begin
    int stall_count;
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus: table set-up, reset, then three phases with different idle rates.
  initial begin
    logic [63:0]  divisor;
    logic [63:0]  partial;
    logic [63:0]  m;
    logic [127:0] prod;
    logic [63:0]  corner_args [$];

    rst_n = 1'b0;

    // log10(2) = 1 / log2(10) by restoring division, then the mantissa table.
    divisor       = (64'd3 << 60) + log2_q60_of(64'd5 << 60);
    partial       = 64'd1 << 60;
    log10_two_q63 = '0;
    for (int k = 0; k < 63; k++) begin
      partial       = partial << 1;
      log10_two_q63 = log10_two_q63 << 1;
      if (partial >= divisor) begin
        partial          = partial - divisor;
        log10_two_q63[0] = 1'b1;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      m    = (64'd1 << 62) + (64'(i) << (62 - TABLE_IDX_W));
      prod = 128'(log2_q60_of(m)) * 128'(log10_two_q63) + (128'd1 << (122 - FRAC_W));
      mant_log_table[i] = 64'(prod >> (123 - FRAC_W));
    end

    // Zeros, signs, subnormals, infinities, NaNs, mantissa extremes and values such as 1, 10 and 0.1.
    corner_args = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
      64'h4024_0000_0000_0000, 64'h3FB9_9999_9999_999A, 64'h0000_0000_0000_0001,
      64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
      64'h7FF0_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FF8_0000_0000_0000,
      64'hFFF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hBFF0_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF, 64'h3FF0_0200_0000_0000, 64'h3FF0_01FF_FFFF_FFFF,
      64'h3FF0_0000_0000_0001, 64'h3FFF_FC00_0000_0000, 64'h3FE0_0000_0000_0000,
      64'h4000_0000_0000_0000
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Each phase ends by waiting until every item is sent and all results are in.
    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 19 : 0;
      if (phase == 0) begin
        foreach (corner_args[i]) begin
          pending_args.push_back(corner_args[i]);
        end
      end
      repeat (ITEMS_PER_PHASE) pending_args.push_back(random_arg());
      while (pending_args.size() != 0 || in_chan.valid || expected_logs.size() != 0) begin
        @(negedge clk);
      end
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
